@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TSTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/tstsc_pkg.sv @@
// Types and constants of the transit speed classifier core.
package tstsc_pkg;

    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned LIMIT_W     = 7;
    localparam int unsigned CLASS_MS_W  = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned RUN_W       = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned SAMPLE_BITS = 10;
    localparam logic [TIME_W-1:0] TIMEOUT_MS = 32'd5000;

    // Bits of sample and dark level that take part in the compare.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} :
        SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef enum logic [1:0] {
        PH_INIT   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_DETECT = 2'd3
    } t_phase;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_SLOWEST = 3'd1,
        CLS_SLOW    = 3'd2,
        CLS_MIDDLE  = 3'd3,
        CLS_FAST    = 3'd4,
        CLS_FASTEST = 3'd5
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_LOW  = 3'd0,
        CFG_DARK_HIGH = 3'd1,
        CFG_LIMIT     = 3'd2,
        CFG_SLOWEST   = 3'd3,
        CFG_SLOW      = 3'd4,
        CFG_MIDDLE    = 3'd5,
        CFG_FAST      = 3'd6,
        CFG_FASTEST   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   dark_low;
        logic [SAMPLE_W-1:0]   dark_high;
        logic [LIMIT_W-1:0]    limit;
        logic [CLASS_MS_W-1:0] slowest_ms;
        logic [CLASS_MS_W-1:0] slow_ms;
        logic [CLASS_MS_W-1:0] middle_ms;
        logic [CLASS_MS_W-1:0] fast_ms;
        logic [CLASS_MS_W-1:0] fastest_ms;
    } t_cfg;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] second_sample;
        logic                range_select;
        logic [TIME_W-1:0]   now_ms;
    } t_item;

    typedef struct packed {
        t_phase            phase;
        t_class            speed_class;
        logic              timed_out;
        logic [TIME_W-1:0] elapsed_ms;
    } t_result;

endpackage

@@ rtl/core/tstsc_classify.sv @@
// Speed class decode of the latched transit time.
module tstsc_classify (
    input  logic [tstsc_pkg::TIME_W-1:0] i_transit_ms,
    input  tstsc_pkg::t_cfg              i_cfg,
    output tstsc_pkg::t_class            o_class
);

    // Thresholds are checked slowest first; first hit wins.
    always_comb begin
        if (i_transit_ms >= tstsc_pkg::TIME_W'(i_cfg.slowest_ms)) begin
            o_class = tstsc_pkg::CLS_SLOWEST;
        end else if (i_transit_ms >= tstsc_pkg::TIME_W'(i_cfg.slow_ms)) begin
            o_class = tstsc_pkg::CLS_SLOW;
        end else if (i_transit_ms >= tstsc_pkg::TIME_W'(i_cfg.middle_ms)) begin
            o_class = tstsc_pkg::CLS_MIDDLE;
        end else if (i_transit_ms >= tstsc_pkg::TIME_W'(i_cfg.fast_ms)) begin
            o_class = tstsc_pkg::CLS_FAST;
        end else if (i_transit_ms >= tstsc_pkg::TIME_W'(i_cfg.fastest_ms)) begin
            o_class = tstsc_pkg::CLS_FASTEST;
        end else begin
            o_class = tstsc_pkg::CLS_NONE;
        end
    end

endmodule

@@ rtl/core/tstsc_phase.sv @@
// Phase state machine: run counter, start time and transit time.
module tstsc_phase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  tstsc_pkg::t_item     i_beat,
    input  tstsc_pkg::t_cfg      i_cfg,
    output tstsc_pkg::t_result   o_res
);

    tstsc_pkg::t_phase                    r_phase, n_phase;
    logic [tstsc_pkg::RUN_W-1:0]          r_run_count, n_run_count;
    logic [tstsc_pkg::TIME_W-1:0]         r_start_time, n_start_time;
    logic [tstsc_pkg::TIME_W-1:0]         r_transit_time, n_transit_time;

    logic                                 confirmed;
    logic                                 covered;
    logic                                 timeout_hit;
    logic [tstsc_pkg::SAMPLE_W-1:0]       sample;
    logic [tstsc_pkg::SAMPLE_W-1:0]       dark_level;
    logic [tstsc_pkg::TIME_W-1:0]         since_start;
    logic [tstsc_pkg::RUN_W-1:0]          run_counted;
    logic                                 timed_out;
    tstsc_pkg::t_class                    cur_class;

    tstsc_classify u_classify (
        .i_transit_ms (r_transit_time),
        .i_cfg        (i_cfg),
        .o_class      (cur_class)
    );

    assign confirmed   = r_run_count > tstsc_pkg::RUN_W'(i_cfg.limit);
    assign sample      = ((r_phase == tstsc_pkg::PH_FIRST) ? i_beat.first_sample
                                                           : i_beat.second_sample)
                         & tstsc_pkg::SAMPLE_MASK;
    assign dark_level  = (i_beat.range_select ? i_cfg.dark_high : i_cfg.dark_low)
                         & tstsc_pkg::SAMPLE_MASK;
    assign covered     = sample <= dark_level;
    assign since_start = i_beat.now_ms - r_start_time;
    assign timeout_hit = (r_run_count == '0) && (since_start >= tstsc_pkg::TIMEOUT_MS);
    assign run_counted = covered ? ((r_run_count == tstsc_pkg::RUN_MAX) ? r_run_count
                                                                        : r_run_count + 1'b1)
                                 : '0;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_beat.op == tstsc_pkg::OP_RESTART) begin
            n_phase = tstsc_pkg::PH_INIT;
        end else begin
            unique case (r_phase)
                tstsc_pkg::PH_INIT:   n_phase = tstsc_pkg::PH_FIRST;
                tstsc_pkg::PH_FIRST: begin
                    if (confirmed) n_phase = tstsc_pkg::PH_SECOND;
                end
                tstsc_pkg::PH_SECOND: begin
                    if (confirmed) begin
                        n_phase = tstsc_pkg::PH_DETECT;
                    end else if (timeout_hit) begin
                        n_phase = tstsc_pkg::PH_INIT;
                    end
                end
                tstsc_pkg::PH_DETECT: n_phase = tstsc_pkg::PH_DETECT;
                default:              n_phase = tstsc_pkg::PH_INIT;
            endcase
        end
    end

    // Datapath updates and result
    always_comb begin
        n_run_count    = r_run_count;
        n_start_time   = r_start_time;
        n_transit_time = r_transit_time;
        timed_out      = 1'b0;
        if (i_beat.op == tstsc_pkg::OP_SAMPLE) begin
            unique case (r_phase)
                tstsc_pkg::PH_INIT: begin
                    n_run_count    = '0;
                    n_transit_time = '0;
                end
                tstsc_pkg::PH_FIRST: begin
                    if (confirmed) begin
                        n_run_count  = '0;
                        n_start_time = i_beat.now_ms;
                    end else begin
                        n_run_count = run_counted;
                    end
                end
                tstsc_pkg::PH_SECOND: begin
                    if (confirmed) begin
                        n_run_count    = '0;
                        n_transit_time = since_start;
                    end else if (timeout_hit) begin
                        timed_out = 1'b1;
                    end else begin
                        n_run_count = run_counted;
                    end
                end
                default: ;
            endcase
        end
        o_res.phase       = n_phase;
        o_res.speed_class = (i_beat.op == tstsc_pkg::OP_SAMPLE &&
                             r_phase == tstsc_pkg::PH_DETECT) ? cur_class
                                                              : tstsc_pkg::CLS_NONE;
        o_res.timed_out   = timed_out;
        o_res.elapsed_ms  = n_transit_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tstsc_pkg::PH_INIT;
            r_run_count    <= '0;
            r_start_time   <= '0;
            r_transit_time <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_run_count    <= n_run_count;
            r_start_time   <= n_start_time;
            r_transit_time <= n_transit_time;
        end
    end

endmodule

@@ rtl/core/two_sensor_transit_speed_classifier_core.sv @@
// An accepted input beat moves through the input register into the result register,
// and waits in the input register while a finished result is held in the result register.
// One beat per cycle unless the result channel stalls; the phase update is a
// single combinational step between the input register and the result register.
// Reset (i_rst_n low at a clock edge) returns phase to init, clears the run
// counter, start and transit times and both valid flags, and reloads config defaults.
// Configuration writes are always accepted and take effect the next cycle.
module two_sensor_transit_speed_classifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [tstsc_pkg::SAMPLE_W-1:0]     i_first_sample,
    input  logic [tstsc_pkg::SAMPLE_W-1:0]     i_second_sample,
    input  logic                               i_range_select,
    input  logic [tstsc_pkg::TIME_W-1:0]       i_now_ms,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_phase,
    output logic [2:0]                         o_speed_class,
    output logic                               o_timed_out,
    output logic [tstsc_pkg::TIME_W-1:0]       o_elapsed_ms,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tstsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tstsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "assert_macros.svh"

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    tstsc_pkg::t_cfg r_cfg;
    tstsc_pkg::t_cfg_idx cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = tstsc_pkg::t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_low   <= 10'd300;
            r_cfg.dark_high  <= 10'd600;
            r_cfg.limit      <= 7'd3;
            r_cfg.slowest_ms <= 16'd2000;
            r_cfg.slow_ms    <= 16'd1000;
            r_cfg.middle_ms  <= 16'd500;
            r_cfg.fast_ms    <= 16'd250;
            r_cfg.fastest_ms <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                tstsc_pkg::CFG_DARK_LOW:  r_cfg.dark_low   <= i_cfg_data[tstsc_pkg::SAMPLE_W-1:0];
                tstsc_pkg::CFG_DARK_HIGH: r_cfg.dark_high  <= i_cfg_data[tstsc_pkg::SAMPLE_W-1:0];
                tstsc_pkg::CFG_LIMIT:     r_cfg.limit      <= i_cfg_data[tstsc_pkg::LIMIT_W-1:0];
                tstsc_pkg::CFG_SLOWEST:   r_cfg.slowest_ms <= i_cfg_data;
                tstsc_pkg::CFG_SLOW:      r_cfg.slow_ms    <= i_cfg_data;
                tstsc_pkg::CFG_MIDDLE:    r_cfg.middle_ms  <= i_cfg_data;
                tstsc_pkg::CFG_FAST:      r_cfg.fast_ms    <= i_cfg_data;
                tstsc_pkg::CFG_FASTEST:   r_cfg.fastest_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Two-stage valid/ready pipe: input register -> result register.
    // The state machine steps when the input-register beat moves into
    // the result register, so state always follows accepted order.
    // ---------------------------------------------------------------
    logic                 r_in_valid;
    tstsc_pkg::t_item     r_in;
    logic                 r_out_valid;
    tstsc_pkg::t_result   r_out;
    tstsc_pkg::t_result   step_res;
    logic                 out_free;
    logic                 step;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload holds while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.op            <= tstsc_pkg::t_op'(i_op);
            r_in.first_sample  <= i_first_sample;
            r_in.second_sample <= i_second_sample;
            r_in.range_select  <= i_range_select;
            r_in.now_ms        <= i_now_ms;
        end
    end

    tstsc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_phase       = r_out.phase;
    assign o_speed_class = r_out.speed_class;
    assign o_timed_out   = r_out.timed_out;
    assign o_elapsed_ms  = r_out.elapsed_ms;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A timeout always drops back to init.
    `TSTSC_ASSERT_NOW(a_tout_init, i_clk, i_rst_n, o_out_valid && o_timed_out,
                      o_phase == tstsc_pkg::PH_INIT)
    // A class is only reported while in detection.
    `TSTSC_ASSERT_NOW(a_class_detect, i_clk, i_rst_n,
                      o_out_valid && (o_speed_class != tstsc_pkg::CLS_NONE),
                      o_phase == tstsc_pkg::PH_DETECT)
    // Input stage stalls only when a result is blocked downstream.
    `TSTSC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
                      r_in_valid && r_out_valid && !i_out_ready)
    // A stepped beat shows up as a result on the next cycle.
    `TSTSC_ASSERT_NEXT(a_step_out, i_clk, i_rst_n, step, o_out_valid)

endmodule
